>>> rtl/b2da_pkg.sv
package b2da_pkg;

    // ASCII code of the digit zero, reduced to the six-bit character field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // BCD digit value at and above which double dabble adds three
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/b2da_front.sv
module b2da_front
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output logic [VALUE_BITS-1:0] o_q_value,
    output logic                  o_q_zero
);

    logic [VALUE_BITS-1:0] r_mem_value [2];
    logic                  r_mem_zero  [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic [1:0]            n_count;
    logic                  push;
    logic                  pop;

    assign o_ready   = (r_count != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_value = r_mem_value[r_rd_ptr];
    assign o_q_zero  = r_mem_zero[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // store the beat with its zero class
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem_value[r_wr_ptr] <= i_value;
            r_mem_zero[r_wr_ptr]  <= (i_value == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/b2da_back.sv
module b2da_back
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_ready,
    input  logic [VALUE_BITS-1:0] i_q_value,
    input  logic                  i_q_zero,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [5:0]            o_digit_char,
    output logic                  o_last_digit
);

    // upper bound on decimal digits: floor(bits * log10(2)) + 1
    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCDW = NDIG * 4;
    localparam int CW   = $clog2(VALUE_BITS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [VALUE_BITS-1:0] r_shift;
    logic [VALUE_BITS-1:0] n_shift;
    logic [BCDW-1:0]     r_bcd;
    logic [BCDW-1:0]     n_bcd;
    logic [BCDW-1:0]     bcd_adj;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic                r_started;
    logic                n_started;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [5:0]          r_out_char;
    logic [5:0]          n_out_char;
    logic                r_out_last;
    logic                n_out_last;
    logic [3:0]          top_digit;
    logic                is_last;
    logic                skip;
    logic                slot_free;
    logic                take;
    logic                emit;

    assign top_digit = r_bcd[BCDW-1 -: 4];
    assign is_last   = (r_cnt == '0);
    assign skip      = (top_digit == 4'd0) && !r_started && !is_last;
    assign slot_free = !r_out_valid || i_ready;
    assign take      = (r_state == ST_IDLE) && i_q_valid;
    assign emit      = (r_state == ST_EMIT) && !skip && slot_free;

    assign o_q_ready    = (r_state == ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    // add three to every digit at five or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*4 +: 4] >= BCD_ADJ_MIN) begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + BCD_ADJ_ADD;
            end else begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) n_state = i_q_zero ? ST_EMIT : ST_CONV;
            end
            ST_CONV: begin
                if (r_cnt == '0) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit && is_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_shift   = i_q_value;
                    n_bcd     = '0;
                    n_started = 1'b0;
                    n_cnt     = i_q_zero ? CW'(NDIG - 1) : CW'(VALUE_BITS - 1);
                end
            end
            ST_CONV: begin
                n_bcd   = {bcd_adj[BCDW-2:0], r_shift[VALUE_BITS-1]};
                n_shift = {r_shift[VALUE_BITS-2:0], 1'b0};
                n_cnt   = (r_cnt == '0) ? CW'(NDIG - 1) : r_cnt - CW'(1);
            end
            ST_EMIT: begin
                if (skip) begin
                    n_bcd = {r_bcd[BCDW-5:0], 4'd0};
                    n_cnt = r_cnt - CW'(1);
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ASCII_ZERO + {2'b00, top_digit};
                    n_out_last  = is_last;
                    n_started   = 1'b1;
                    if (!is_last) begin
                        n_bcd = {r_bcd[BCDW-5:0], 4'd0};
                        n_cnt = r_cnt - CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_bcd      <= n_bcd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// Input channel (i_valid / o_ready, i_value): one beat carries an unsigned
// VALUE_BITS-bit number. Output channel (o_valid / i_ready): one beat per
// decimal character, most significant digit first, leading zeros dropped;
// o_digit_char holds '0'..'9' and o_last_digit marks the final character.
// A zero value gives the single character '0'.
// Structure: a front stage takes input beats into a two-entry queue and tags
// zero values; the back stage runs a bit-serial double-dabble conversion,
// one input bit per cycle, then walks the BCD digits one per cycle,
// each emitted digit waiting until the output register is free.
// Per item: the back takes it from the queue, runs one shift-add-3 step
// per input bit (skipped for zero), then skips or emits each BCD digit
// position (10 for 32 bits). The back handles one item at a time;
// the queue keeps accepting up to two further items meanwhile.
// Reset (i_rst_n low at a clock edge) empties the queue, returns the
// converter to idle and drops any pending output character.
// When the receiver stalls, the output register holds its character and the
// walk waits; the queue then fills and o_ready falls.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [5:0]            o_digit_char,
    output logic                  o_last_digit
);

    // queue head toward the converter
    logic                  q_valid;
    logic                  q_ready;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_zero;

    b2da_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_value   (i_value),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_value (q_value),
        .o_q_zero  (q_zero)
    );

    b2da_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_ready    (q_ready),
        .i_q_value    (q_value),
        .i_q_zero     (q_zero),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule
